// File: src/bavg_pkg.sv
// Package for the block-averaging converter accumulator.
// Widths, limits, divider request/response structs and the sequencer state type.
// No dependencies.
`default_nettype none
package bavg_pkg;

	localparam int SAMPLE_W  = 10;
	localparam int LEN_W     = 11;
	localparam int SUM_W     = 21;
	localparam int CNT_W     = 11;
	localparam int Q8_W      = 18;
	localparam int TEN_W     = 14;
	localparam int NUM_W     = 16;

	localparam logic [LEN_W-1:0] MAX_BLOCK = LEN_W'(2000);

	// divider: quotient bits, divisor bits, dividend = both together
	localparam int QUO_W  = 18;
	localparam int DIVS_W = CNT_W + 1;
	localparam int DIVD_W = DIVS_W + QUO_W;
	localparam int ITER_W = 5;

	localparam logic [ITER_W-1:0] Q8_ITERS  = ITER_W'(Q8_W);
	localparam logic [ITER_W-1:0] TEN_ITERS = ITER_W'(TEN_W);

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
		logic [ITER_W-1:0] iters;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_Q8   = 4'b0010,
		ST_TEN  = 4'b0100,
		ST_OUT  = 4'b1000
	} seq_state_t;

endpackage
`default_nettype wire

// File: src/bavg_if.sv
// Valid/ready channel interfaces: sample input and averaged result output.
// Depends on bavg_pkg for field widths.
`default_nettype none
interface bavg_in_if;
	logic                           valid;
	logic                           ready;
	logic [bavg_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface bavg_out_if;
	logic                        valid;
	logic                        ready;
	logic [bavg_pkg::SUM_W-1:0] block_sum;
	logic [bavg_pkg::CNT_W-1:0] block_count;
	logic [bavg_pkg::Q8_W-1:0]  mean_q8;
	logic [bavg_pkg::TEN_W-1:0] mean_tenths;
	logic [bavg_pkg::NUM_W-1:0] result_number;

	modport source (output valid, output block_sum, output block_count, output mean_q8,
		output mean_tenths, output result_number, input ready);
	modport sink   (input valid, input block_sum, input block_count, input mean_q8,
		input mean_tenths, input result_number, output ready);
endinterface
`default_nettype wire

// File: src/bavg_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on bavg_pkg (div_req_t, div_rsp_t, widths).
`default_nettype none
module bavg_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bavg_pkg::div_req_t req,
	output bavg_pkg::div_rsp_t      rsp
);
	localparam int QW = bavg_pkg::QUO_W;
	localparam int SW = bavg_pkg::DIVS_W;

	logic [SW-1:0]               rem_q;
	logic [QW-1:0]               low_q;
	logic [QW-1:0]               quo_q;
	logic [SW-1:0]               dvs_q;
	logic [bavg_pkg::ITER_W-1:0] cnt_q;
	logic                        done_q;

	logic [SW:0]   trial;
	logic [SW:0]   diff;
	logic          qbit;
	logic [SW-1:0] rem_nxt;

	// partial remainder stays below divisor; caller guarantees the top bits start below it
	always_comb begin
		trial   = {rem_q, low_q[QW-1]};
		diff    = trial - {1'b0, dvs_q};
		qbit    = (trial >= {1'b0, dvs_q});
		rem_nxt = qbit ? diff[SW-1:0] : trial[SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= req.iters;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == bavg_pkg::ITER_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend[bavg_pkg::DIVD_W-1:QW];
			low_q <= req.dividend[QW-1:0];
			dvs_q <= req.divisor;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= rem_nxt;
			low_q <= {low_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], qbit};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule
`default_nettype wire

// File: src/block_averaging_adc_accumulator_top.sv
// Top level of the block-averaging converter accumulator (boxcar accumulate and dump).
// Depends on bavg_pkg, bavg_in_if / bavg_out_if and bavg_div.
//
//  channel   dir  handshake        payload
//  samples   in   valid/ready      sample[9:0]
//  results   out  valid/ready      block_sum, block_count, mean_q8, mean_tenths, result_number
//  cfg       in   cfg_we (no wait) cfg_wdata[10:0] = block_length
//
// A sample that does not close a block is taken while ready stays high.
// The sample that closes a block holds ready low while the one shared divider runs
// 18 steps for the Q.8 mean and then 14 for the tenths mean, and until the result is
// loaded into the output register, which waits while that register is still full.
// A finished result sits in the output register, so new samples are taken while
// it waits. Reset (arst_n, async) sets the block length to 1 and clears the sums;
// a write of cfg in the idle state (ready high) clears the running sum, count and result number.
`default_nettype none
module block_averaging_adc_accumulator_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	bavg_in_if.sink                          samples,
	bavg_out_if.source                       results,
	input  wire logic                        cfg_we,
	input  wire logic [bavg_pkg::LEN_W-1:0] cfg_wdata
);
	localparam int SUMW = bavg_pkg::SUM_W;
	localparam int CNTW = bavg_pkg::CNT_W;
	localparam int DW   = bavg_pkg::DIVD_W;

	bavg_pkg::seq_state_t state_q;

	logic [CNTW-1:0]               eff_len_q;   // clamped block length
	logic [SUMW-1:0]               sum_q;
	logic [CNTW-1:0]               count_q;
	logic [bavg_pkg::NUM_W-1:0]    num_q;

	// finished block, held while the divider runs
	logic [SUMW-1:0]               blk_sum_q;
	logic [CNTW-1:0]               blk_cnt_q;
	logic [bavg_pkg::Q8_W-1:0]     q8_q;
	logic [bavg_pkg::TEN_W-1:0]    ten_q;

	// output register
	logic                          out_valid_q;
	logic [SUMW-1:0]               out_sum_q;
	logic [CNTW-1:0]               out_cnt_q;
	logic [bavg_pkg::Q8_W-1:0]     out_q8_q;
	logic [bavg_pkg::TEN_W-1:0]    out_ten_q;
	logic [bavg_pkg::NUM_W-1:0]    out_num_q;

	bavg_pkg::div_req_t div_req;
	bavg_pkg::div_rsp_t div_rsp;

	logic            accept;
	logic [SUMW-1:0] sum_nxt;
	logic [CNTW-1:0] cnt_nxt;
	logic            closes;
	logic            out_free;
	logic [CNTW-1:0] len_clamped;
	logic [DW-1:0]   q8_dividend;
	logic [25:0]     ten_num;       // 20*sum + cnt, below 2^26
	logic [DW-1:0]   ten_dividend;

	assign accept   = samples.valid && samples.ready;
	assign sum_nxt  = sum_q + SUMW'(samples.sample);
	assign cnt_nxt  = count_q + 1'b1;
	assign closes   = (cnt_nxt >= eff_len_q);
	assign out_free = !out_valid_q || results.ready;

	always_comb begin
		if (cfg_wdata == '0) begin
			len_clamped = CNTW'(1);
		end else if (cfg_wdata > bavg_pkg::MAX_BLOCK) begin
			len_clamped = bavg_pkg::MAX_BLOCK;
		end else begin
			len_clamped = cfg_wdata;
		end
	end

	// round half up: (2*sum*k + cnt) / (2*cnt)
	assign q8_dividend  = {sum_nxt, 9'b0} + DW'(cnt_nxt);
	assign ten_num      = {1'b0, blk_sum_q, 4'b0} + {3'b0, blk_sum_q, 2'b0} + 26'(blk_cnt_q);
	// left-aligned so the divider's top bits start as the partial remainder
	assign ten_dividend = {ten_num, 4'b0};

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = q8_dividend;
		div_req.divisor  = {cnt_nxt, 1'b0};
		div_req.iters    = bavg_pkg::Q8_ITERS;
		unique case (state_q)
			bavg_pkg::ST_IDLE: begin
				div_req.start = accept && closes;
			end
			bavg_pkg::ST_Q8: begin
				div_req.start    = div_rsp.done;
				div_req.dividend = ten_dividend;
				div_req.divisor  = {blk_cnt_q, 1'b0};
				div_req.iters    = bavg_pkg::TEN_ITERS;
			end
			bavg_pkg::ST_TEN: ;
			bavg_pkg::ST_OUT: ;
			default: ;
		endcase
	end

	bavg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign samples.ready = (state_q == bavg_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bavg_pkg::ST_IDLE;
			eff_len_q   <= CNTW'(1);
			sum_q       <= '0;
			count_q     <= '0;
			num_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load wins over drain; a taken beat frees the register
			if (state_q == bavg_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				bavg_pkg::ST_IDLE: begin
					if (cfg_we) begin
						eff_len_q <= len_clamped;
						sum_q     <= '0;
						count_q   <= '0;
						num_q     <= '0;
					end else if (accept) begin
						if (closes) begin
							sum_q   <= '0;
							count_q <= '0;
							num_q   <= num_q + 1'b1;
							state_q <= bavg_pkg::ST_Q8;
						end else begin
							sum_q   <= sum_nxt;
							count_q <= cnt_nxt;
						end
					end
				end
				bavg_pkg::ST_Q8: begin
					if (div_rsp.done) begin
						state_q <= bavg_pkg::ST_TEN;
					end
				end
				bavg_pkg::ST_TEN: begin
					if (div_rsp.done) begin
						state_q <= bavg_pkg::ST_OUT;
					end
				end
				bavg_pkg::ST_OUT: begin
					if (out_free) begin
						state_q <= bavg_pkg::ST_IDLE;
					end
				end
				default: state_q <= bavg_pkg::ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == bavg_pkg::ST_IDLE && accept && closes) begin
			blk_sum_q <= sum_nxt;
			blk_cnt_q <= cnt_nxt;
		end
		if (state_q == bavg_pkg::ST_Q8 && div_rsp.done) begin
			q8_q <= div_rsp.quotient;
		end
		if (state_q == bavg_pkg::ST_TEN && div_rsp.done) begin
			ten_q <= div_rsp.quotient[bavg_pkg::TEN_W-1:0];
		end
		if (state_q == bavg_pkg::ST_OUT && out_free) begin
			out_sum_q <= blk_sum_q;
			out_cnt_q <= blk_cnt_q;
			out_q8_q  <= q8_q;
			out_ten_q <= ten_q;
			out_num_q <= num_q;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.block_sum     = out_sum_q;
	assign results.block_count   = out_cnt_q;
	assign results.mean_q8       = out_q8_q;
	assign results.mean_tenths   = out_ten_q;
	assign results.result_number = out_num_q;

endmodule
`default_nettype wire
